### sv/assert_macros.svh
// assertion macros for the keyer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define MCK_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when the antecedent holds, the consequent holds in the same cycle
`define MCK_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### sv/mck_pkg.sv
// shared types, constants and the morse code table of the character keyer
`default_nettype none

package mck_pkg;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // special characters and character ranges
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TBL_LO  = 8'd39;
  localparam logic [7:0] CH_TBL_HI  = 8'd90;
  localparam logic [7:0] CH_LOW_A   = 8'd97;
  localparam logic [7:0] CH_LOW_Z   = 8'd122;
  localparam logic [7:0] TBL_BASE   = 8'd38;
  localparam logic [7:0] CASE_FOLD  = 8'd32;

  // table index width and the entries with special meaning
  localparam int IDX_W = 6;
  typedef logic [IDX_W-1:0] idx_t;
  localparam idx_t IDX_SPACE    = 6'd0;
  localparam idx_t IDX_UNMAPPED = 6'd53;

  // table codes with special meaning
  localparam logic [7:0] CODE_SPACE = 8'h01;
  localparam logic [7:0] CODE_NONE  = 8'h00;

  // segment lengths in dit units
  localparam logic [2:0] UNITS_DIT       = 3'd1;
  localparam logic [2:0] UNITS_DAH       = 3'd3;
  localparam logic [2:0] UNITS_ELEM_GAP  = 3'd1;
  localparam logic [2:0] UNITS_CHAR_GAP  = 3'd2;
  localparam logic [2:0] UNITS_WORD_GAP  = 3'd4;
  localparam logic [2:0] UNITS_MAX       = 3'd4;

  // one classified character: elements aligned so the next one sits in bit 0
  typedef struct packed {
    logic       is_space;
    logic [2:0] cnt;
    logic [6:0] elems;
  } desc_t;

  // one keying segment
  typedef struct packed {
    logic       key_on;
    logic [2:0] units;
    logic       last;
  } seg_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // morse table: filler zeros, start bit, then elements (1 dit, 0 dah) from lsb up
  function automatic logic [7:0] code_lut(input idx_t idx);
    logic [7:0] code;
    case (idx)
      6'd0:  code = 8'h01;
      6'd1:  code = 8'h86;
      6'd2:  code = 8'h94;
      6'd3:  code = 8'h4A;
      6'd4:  code = 8'h00;
      6'd5:  code = 8'hAC;
      6'd6:  code = 8'h32;
      6'd7:  code = 8'h7A;
      6'd8:  code = 8'h56;
      6'd9:  code = 8'hB4;
      6'd10: code = 8'h04;
      6'd11: code = 8'h0C;
      6'd12: code = 8'h1C;
      6'd13: code = 8'h3C;
      6'd14: code = 8'h7C;
      6'd15: code = 8'hFC;
      6'd16: code = 8'hF4;
      6'd17: code = 8'hE4;
      6'd18: code = 8'hC4;
      6'd19: code = 8'h84;
      6'd20: code = 8'hE2;
      6'd21: code = 8'hAA;
      6'd22: code = 8'h00;
      6'd23: code = 8'h74;
      6'd24: code = 8'h5E;
      6'd25: code = 8'hCE;
      6'd26: code = 8'hA6;
      6'd27: code = 8'h60;
      6'd28: code = 8'hE8;
      6'd29: code = 8'hA8;
      6'd30: code = 8'hD0;
      6'd31: code = 8'hC0;
      6'd32: code = 8'hB8;
      6'd33: code = 8'h90;
      6'd34: code = 8'hF8;
      6'd35: code = 8'hE0;
      6'd36: code = 8'h18;
      6'd37: code = 8'h50;
      6'd38: code = 8'hD8;
      6'd39: code = 8'h20;
      6'd40: code = 8'hA0;
      6'd41: code = 8'h10;
      6'd42: code = 8'h98;
      6'd43: code = 8'h48;
      6'd44: code = 8'hB0;
      6'd45: code = 8'hF0;
      6'd46: code = 8'h40;
      6'd47: code = 8'h70;
      6'd48: code = 8'h78;
      6'd49: code = 8'h30;
      6'd50: code = 8'h68;
      6'd51: code = 8'h28;
      6'd52: code = 8'hC8;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### sv/mck_if.sv
// valid/ready channel interfaces for characters in and keying segments out
`default_nettype none

interface mck_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface mck_out_if;
  logic       valid;
  logic       ready;
  logic       key_on;
  logic [2:0] units;
  logic       last;

  modport source (output valid, output key_on, output units, output last, input ready);
  modport sink (input valid, input key_on, input units, input last, output ready);
endinterface

`default_nettype wire

### sv/mck_front.sv
// front: accepts characters, looks up the code and queues a descriptor
`default_nettype none

module mck_front (
  mck_in_if.sink          in_ch,
  input  mck_pkg::q_stat_t q_stat,
  output logic            q_push,
  output mck_pkg::desc_t  q_desc
);

  mck_pkg::idx_t idx;
  logic [7:0]    code;
  logic [7:0]    sub;
  logic [2:0]    start_pos;
  logic [3:0]    shift_amt;
  logic [7:0]    shifted;

  // character to table index, lowercase folded to uppercase
  always_comb begin
    sub = 8'd0;
    if (in_ch.ch == mck_pkg::CH_SPACE || in_ch.ch == mck_pkg::CH_NEWLINE) begin
      idx = mck_pkg::IDX_SPACE;
    end else if (in_ch.ch inside {[mck_pkg::CH_LOW_A:mck_pkg::CH_LOW_Z]}) begin
      sub = in_ch.ch - mck_pkg::CASE_FOLD - mck_pkg::TBL_BASE;
      idx = sub[mck_pkg::IDX_W-1:0];
    end else if (in_ch.ch inside {[mck_pkg::CH_TBL_LO:mck_pkg::CH_TBL_HI]}) begin
      sub = in_ch.ch - mck_pkg::TBL_BASE;
      idx = sub[mck_pkg::IDX_W-1:0];
    end else begin
      idx = mck_pkg::IDX_UNMAPPED;
    end
  end

  assign code = mck_pkg::code_lut(idx);

  // locate the start bit, the lowest set bit of the code
  always_comb begin
    start_pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (code[i]) begin
        start_pos = i[2:0];
      end
    end
  end

  // elements follow the start bit
  assign shift_amt = {1'b0, start_pos} + 4'd1;
  assign shifted   = code >> shift_amt;

  always_comb begin
    q_desc.is_space = (code == mck_pkg::CODE_SPACE);
    q_desc.cnt      = 3'd7 - start_pos;
    q_desc.elems    = shifted[6:0];
  end

  // unmapped characters are taken and dropped
  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && in_ch.ready && (code != mck_pkg::CODE_NONE);

endmodule

`default_nettype wire

### sv/mck_queue.sv
// short descriptor queue between front and back
`default_nettype none

module mck_queue #(
  parameter int DEPTH = mck_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mck_pkg::desc_t   push_desc,
  input  logic             pop,
  output mck_pkg::desc_t   head_desc,
  output mck_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mck_pkg::desc_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // status and head entry
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_desc    = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

### sv/mck_back.sv
// back: steps through the elements of a character, one segment per cycle while the output is not stalled
`default_nettype none

module mck_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mck_pkg::desc_t   q_desc,
  input  mck_pkg::q_stat_t q_stat,
  output logic             q_pop,
  mck_out_if.source        out_seg
);

  mck_pkg::desc_t cur_r, cur_nxt;
  logic           cur_vld_r, cur_vld_nxt;
  logic           phase_r, phase_nxt;
  logic           out_vld_r, out_vld_nxt;
  mck_pkg::seg_t  seg_r, seg_nxt;
  mck_pkg::seg_t  seg;
  logic           out_free;
  logic           adv;
  logic           done;

  // segment for the current step: tone, element gap or closing gap
  always_comb begin
    if (cur_r.is_space) begin
      seg = '{key_on: 1'b0, units: mck_pkg::UNITS_WORD_GAP, last: 1'b1};
    end else if (cur_r.cnt != 3'd0) begin
      if (!phase_r) begin
        seg = '{key_on: 1'b1,
                units: cur_r.elems[0] ? mck_pkg::UNITS_DIT : mck_pkg::UNITS_DAH,
                last: 1'b0};
      end else begin
        seg = '{key_on: 1'b0, units: mck_pkg::UNITS_ELEM_GAP, last: 1'b0};
      end
    end else begin
      seg = '{key_on: 1'b0, units: mck_pkg::UNITS_CHAR_GAP, last: 1'b1};
    end
  end

  // step control and queue pop
  assign out_free = !out_vld_r || out_seg.ready;
  assign adv      = cur_vld_r && out_free;
  assign done     = adv && seg.last;
  assign q_pop    = !q_stat.empty && (!cur_vld_r || done);

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    phase_nxt   = phase_r;
    if (q_pop) begin
      cur_nxt     = q_desc;
      cur_vld_nxt = 1'b1;
      phase_nxt   = 1'b0;
    end else if (done) begin
      cur_vld_nxt = 1'b0;
    end else if (adv && !cur_r.is_space && cur_r.cnt != 3'd0) begin
      if (!phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt     = 1'b0;
        cur_nxt.elems = cur_r.elems >> 1;
        cur_nxt.cnt   = cur_r.cnt - 3'd1;
      end
    end
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    seg_nxt     = seg_r;
    if (out_free) begin
      out_vld_nxt = adv;
    end
    if (adv) begin
      seg_nxt = seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      phase_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cur_r <= cur_nxt;
    seg_r <= seg_nxt;
  end

  assign out_seg.valid  = out_vld_r;
  assign out_seg.key_on = seg_r.key_on;
  assign out_seg.units  = seg_r.units;
  assign out_seg.last   = seg_r.last;

endmodule

`default_nettype wire

### sv/morse_char_keyer_unit.sv
// morse character keyer: ascii bytes in, keying segments out
//
// in_ch carries one ascii byte per transfer; out_seg carries keying segments
// (key_on, units in dit units, last on the final segment of a character).
// letters, digits and punctuation give a tone segment and a 1-unit off
// segment per element, then a 2-unit off gap; space and newline give one
// 4-unit off segment; unmapped bytes are taken and give nothing.
// a character's first segment is held in the queue, the current-character
// register, then the output register. the back end emits one segment per
// cycle while the receiver takes them, so a character with n elements gives
// 2n+1 segments (13 at most), a space one. the front classifies one byte per
// cycle into a QUEUE_DEPTH-entry queue, taking bytes back to back until full.
// when the receiver stalls, the output register holds its segment and the
// back end waits; the queue keeps taking bytes until full, then in_ch.ready
// drops. reset empties the queue and the output register.
`default_nettype none
`include "assert_macros.svh"

module morse_char_keyer_unit #(
  parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  mck_in_if.sink    in_ch,
  mck_out_if.source out_seg
);

  logic             q_push;
  logic             q_pop;
  mck_pkg::desc_t   push_desc;
  mck_pkg::desc_t   head_desc;
  mck_pkg::q_stat_t q_stat;
  logic             seg_units_ok;

  // classify incoming characters
  mck_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_desc (push_desc)
  );

  // descriptor queue
  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head_desc (head_desc),
    .q_stat    (q_stat)
  );

  // segment sequencer and output register
  mck_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_desc  (head_desc),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .out_seg (out_seg)
  );

  // segment length within the legal range
  assign seg_units_ok = (out_seg.units != 3'd0) && (out_seg.units <= mck_pkg::UNITS_MAX);

  // checks on segments and queue handling
  `MCK_ASSERT_IMPL(a_units_range, out_seg.valid, seg_units_ok, "segment length out of range")
  `MCK_ASSERT_IMPL(a_tone_not_last, out_seg.valid && out_seg.key_on, !out_seg.last, "tone last")
  `MCK_ASSERT_ALWAYS(a_queue_stat, !(q_stat.full && q_stat.empty), "queue full and empty")
  `MCK_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire
